### design/lzwd_pkg.sv
// shared types and constants for the lzss window decoder
`default_nettype none
package lzwd_pkg;

    localparam int LZWD_WINDOW_SIZE  = 4096;
    localparam int LZWD_BYTE_W       = 8;
    localparam int LZWD_POS_W        = 12;
    localparam int LZWD_LEN_CODE_W   = 4;
    localparam int LZWD_LEN_W        = 5;
    localparam int LZWD_MIN_LEN      = 3;
    localparam int LZWD_START_OFFSET = 'h12;
    localparam int LZWD_CFG_W        = 16;

    typedef struct packed {
        logic                       valid;
        logic                       literal;
        logic [LZWD_BYTE_W-1:0]     data;
        logic [LZWD_POS_W-1:0]      pos;
        logic [LZWD_LEN_CODE_W-1:0] len_code;
    } t_run_req;

    typedef struct packed {
        logic idle;
        logic slot_free;
    } t_seq_stat;

endpackage
`default_nettype wire

### design/lzwd_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### design/lzwd_copy_seq.sv
// copy sequencer: history window, write pointer and output register
`default_nettype none
module lzwd_copy_seq
    import lzwd_pkg::*;
#(
    parameter int WINDOW_SIZE = LZWD_WINDOW_SIZE
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_run_req               i_req,
    output t_seq_stat                   o_stat,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic      [LZWD_BYTE_W-1:0] o_out_byte,
    output logic                        o_last_of_run
);

    localparam int AW = $clog2(WINDOW_SIZE);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [AW-1:0]          r_wp, n_wp;
    logic [AW:0]            r_wc, n_wc;
    logic [AW-1:0]          r_src, n_src;
    logic [LZWD_LEN_W-1:0]  r_cnt, n_cnt;
    logic                   r_zero, n_zero;
    logic                   r_out_valid, n_out_valid;
    logic [LZWD_BYTE_W-1:0] r_out_byte, n_out_byte;
    logic                   r_last, n_last;

    logic                   slot_free;
    logic [AW-1:0]          start;
    logic [AW-1:0]          diff;
    logic [AW:0]            back_dist;
    logic                   ram_we;
    logic [LZWD_BYTE_W-1:0] ram_wdata;
    logic                   ram_re;
    logic [LZWD_BYTE_W-1:0] ram_rdata;
    logic                   bump;

    assign slot_free = !r_out_valid || i_out_ready;
    assign start     = AW'(r_wp - r_wp + AW'(i_req.pos) + AW'(LZWD_START_OFFSET));
    assign diff      = AW'(start - r_wp);
    assign back_dist = (AW+1)'(WINDOW_SIZE) - {1'b0, diff};

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_wc        = r_wc;
        n_src       = r_src;
        n_cnt       = r_cnt;
        n_zero      = r_zero;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_last      = r_last;
        ram_we      = 1'b0;
        ram_wdata   = i_req.data;
        ram_re      = 1'b0;
        bump        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.literal) begin
                        ram_we      = 1'b1;
                        ram_wdata   = i_req.data;
                        n_out_valid = 1'b1;
                        n_out_byte  = i_req.data;
                        n_last      = 1'b1;
                        bump        = 1'b1;
                    end else begin
                        n_src   = AW'(r_wp - back_dist[AW-1:0]);
                        n_zero  = back_dist > r_wc;
                        n_cnt   = LZWD_LEN_W'(i_req.len_code) + LZWD_LEN_W'(LZWD_MIN_LEN);
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    ram_we      = 1'b1;
                    ram_wdata   = r_zero ? '0 : ram_rdata;
                    n_out_valid = 1'b1;
                    n_out_byte  = ram_wdata;
                    n_last      = (r_cnt == LZWD_LEN_W'(1));
                    n_src       = AW'(r_src + 1'b1);
                    n_cnt       = LZWD_LEN_W'(r_cnt - 1'b1);
                    bump        = 1'b1;
                    n_state     = (r_cnt == LZWD_LEN_W'(1)) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (bump) begin
            n_wp = AW'(r_wp + 1'b1);
            if (r_wc < (AW+1)'(WINDOW_SIZE)) begin
                n_wc = (AW+1)'(r_wc + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_wc        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_wc        <= n_wc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_zero     <= n_zero;
        r_out_byte <= n_out_byte;
        r_last     <= n_last;
    end

    lzwd_ram #(
        .WIDTH(LZWD_BYTE_W),
        .DEPTH(WINDOW_SIZE)
    ) u_history (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wp),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_src),
        .o_rdata(ram_rdata)
    );

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.slot_free = slot_free;
    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_last_of_run    = r_last;

`ifndef SYNTHESIS
    a_read_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> r_state == S_EMIT)
        else $error("read cycle not followed by emit");
    a_busy_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_cnt != '0)
        else $error("copy active with zero count");
    a_wc_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wc <= (AW+1)'(WINDOW_SIZE))
        else $error("written count above window size");
    a_no_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !i_req.valid)
        else $error("run request while copy active");
`endif

endmodule
`default_nettype wire

### design/lzss_window_decoder_core.sv
// top level of the lzss window decoder: command parser and copy sequencer
`default_nettype none
// Decodes an LZSS stream with a 4096-byte history. A descriptor byte, the
// low byte of a match and a stopped byte each give no output; a literal
// gives one transfer. A match sets up the run and then produces 3 to 18
// bytes, each as one read and then one write of the single history ram;
// output back-pressure holds the write back. No input is taken while a
// match runs or while the output register holds a byte that cannot leave.
// The history is not cleared after reset. compressed_length is sampled at
// each command boundary and should be written while the block is idle.
module lzss_window_decoder_core
    import lzwd_pkg::*;
#(
    parameter int WINDOW_SIZE = LZWD_WINDOW_SIZE
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [LZWD_CFG_W-1:0]  i_compressed_length,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [LZWD_BYTE_W-1:0] i_in_byte,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic      [LZWD_BYTE_W-1:0] o_out_byte,
    output logic                        o_last_of_run
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_CMD   = 2'd1;
    localparam logic [1:0] PH_HIGH  = 2'd2;

    logic [LZWD_CFG_W-1:0]  r_len_cfg;
    logic [LZWD_CFG_W-1:0]  r_consumed, n_consumed;
    logic [7:0]             r_flags, n_flags;
    logic [3:0]             r_flags_left, n_flags_left;
    logic [1:0]             r_phase, n_phase;
    logic [LZWD_BYTE_W-1:0] r_saved_low, n_saved_low;

    t_run_req  req;
    t_seq_stat stat;
    logic      fire;
    logic      count_in;

    assign o_in_ready = stat.idle && stat.slot_free;
    assign fire       = i_in_valid && o_in_ready;

    always_comb begin
        n_consumed   = r_consumed;
        n_flags      = r_flags;
        n_flags_left = r_flags_left;
        n_phase      = r_phase;
        n_saved_low  = r_saved_low;
        count_in     = 1'b0;
        req.valid    = 1'b0;
        req.literal  = 1'b0;
        req.data     = i_in_byte;
        req.pos      = {i_in_byte[7:4], r_saved_low};
        req.len_code = i_in_byte[3:0];
        if (fire) begin
            if (r_phase == PH_HIGH) begin
                count_in  = 1'b1;
                n_phase   = PH_START;
                req.valid = 1'b1;
            end else if (r_phase != PH_CMD && r_consumed >= r_len_cfg) begin
                n_phase = r_phase;
            end else if (r_phase != PH_CMD && r_flags_left == 4'd0) begin
                n_flags      = i_in_byte;
                n_flags_left = 4'd8;
                count_in     = 1'b1;
                n_phase      = PH_CMD;
            end else begin
                count_in     = 1'b1;
                n_flags      = {1'b0, r_flags[7:1]};
                n_flags_left = 4'(r_flags_left - 1'b1);
                if (r_flags[0]) begin
                    n_phase     = PH_START;
                    req.valid   = 1'b1;
                    req.literal = 1'b1;
                end else begin
                    n_saved_low = i_in_byte;
                    n_phase     = PH_HIGH;
                end
            end
        end
        if (count_in && r_consumed != '1) begin
            n_consumed = LZWD_CFG_W'(r_consumed + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg    <= '0;
            r_consumed   <= '0;
            r_flags      <= '0;
            r_flags_left <= '0;
            r_phase      <= PH_START;
            r_saved_low  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_len_cfg <= i_compressed_length;
            end
            r_consumed   <= n_consumed;
            r_flags      <= n_flags;
            r_flags_left <= n_flags_left;
            r_phase      <= n_phase;
            r_saved_low  <= n_saved_low;
        end
    end

    lzwd_copy_seq #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_copy_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run)
    );

`ifndef SYNTHESIS
    a_high_follows_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HIGH |-> $past(r_phase) == PH_HIGH || $past(r_phase) == PH_CMD
            || $past(r_phase) == PH_START)
        else $error("match high phase from unexpected phase");
    a_desc_loads_eight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_phase == PH_START && r_consumed < r_len_cfg && r_flags_left == 4'd0
            |=> r_flags_left == 4'd8 && r_phase == PH_CMD)
        else $error("descriptor did not load flags");
    a_flags_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags_left <= 4'd8)
        else $error("flag count above eight");
`endif

endmodule
`default_nettype wire

### test/testbench.sv
// testbench for lzss_window_decoder_core: directed and random compressed streams checked by a predictor
module testbench;
    import lzwd_pkg::*;

    typedef enum logic [1:0] {
        PH_CMD_START  = 2'd0,
        PH_DESC_TAKEN = 2'd1,
        PH_MATCH_LOW  = 2'd2
    } t_dec_phase;

    typedef struct packed {
        logic [LZWD_BYTE_W-1:0] data;
        logic                   last;
    } t_out_byte;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [LZWD_CFG_W-1:0]  i_compressed_length;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [LZWD_BYTE_W-1:0] i_in_byte;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [LZWD_BYTE_W-1:0] o_out_byte;
    logic                   o_last_of_run;

    // predictor state
    logic [7:0]            hist_mem [0:LZWD_WINDOW_SIZE-1];
    logic [11:0]           wr_ptr;
    logic [12:0]           written_cnt;
    logic [15:0]           consumed_cnt;
    logic [7:0]            flag_sr;
    logic [3:0]            flags_left;
    t_dec_phase            dec_phase;
    logic [7:0]            saved_low;
    logic [15:0]           stop_len;
    t_out_byte             expected_out [$];

    int in_idle_pct;
    int out_stall_pct;
    int hold_cycles;
    int taken_items;
    int fail_cnt;

    lzss_window_decoder_core u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_compressed_length (i_compressed_length),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_in_byte           (i_in_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_out_byte          (o_out_byte),
        .o_last_of_run       (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void take_count();
        if (consumed_cnt != 16'hFFFF) consumed_cnt = consumed_cnt + 1'b1;
    endfunction

    function automatic void emit_byte(input logic [7:0] b, input logic last);
        t_out_byte item;
        hist_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        if (written_cnt < 13'(LZWD_WINDOW_SIZE)) written_cnt = written_cnt + 1'b1;
        item.data = b;
        item.last = last;
        expected_out.push_back(item);
    endfunction

    // returns 1 when the byte is consumed, 0 when the decoder is stopped
    function automatic logic decode_byte(input logic [7:0] b);
        logic [11:0] pos;
        logic [11:0] start;
        logic [4:0]  run_len;
        logic [12:0] back_dist;
        logic        zero_fill;
        logic        flag;
        int          i;
        if (dec_phase == PH_MATCH_LOW) begin
            pos = {b[7:4], saved_low};
            run_len = {1'b0, b[3:0]} + 5'(LZWD_MIN_LEN);
            start = pos + 12'(LZWD_START_OFFSET);
            back_dist = 13'(LZWD_WINDOW_SIZE) - {1'b0, 12'(start - wr_ptr)};
            zero_fill = back_dist > written_cnt;
            take_count();
            dec_phase = PH_CMD_START;
            for (i = 0; i < run_len; i++) begin
                emit_byte(zero_fill ? 8'h00 : hist_mem[12'(wr_ptr - back_dist[11:0])],
                          i == run_len - 1);
            end
            return 1'b1;
        end
        if (dec_phase != PH_DESC_TAKEN) begin
            if (consumed_cnt >= stop_len) return 1'b0;
            if (flags_left == 4'd0) begin
                flag_sr = b;
                flags_left = 4'd8;
                take_count();
                dec_phase = PH_DESC_TAKEN;
                return 1'b1;
            end
        end
        take_count();
        flag = flag_sr[0];
        flag_sr = flag_sr >> 1;
        flags_left = flags_left - 1'b1;
        if (flag) begin
            dec_phase = PH_CMD_START;
            emit_byte(b, 1'b1);
        end else begin
            saved_low = b;
            dec_phase = PH_MATCH_LOW;
        end
        return 1'b1;
    endfunction

    function automatic logic [11:0] pos_for_dist(input int d);
        return 12'(wr_ptr - d[11:0] - 12'(LZWD_START_OFFSET));
    endfunction

    // mostly back references into written history, some arbitrary positions
    function automatic logic [11:0] pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (written_cnt == 0 || r < 20) return 12'($urandom);
        if (r < 55) return pos_for_dist($urandom_range(1, written_cnt < 4 ? written_cnt : 4));
        return pos_for_dist($urandom_range(1, written_cnt));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (decode_byte(b)) taken_items++;
    endtask

    task automatic send_match(input logic [11:0] pos, input logic [3:0] len_code);
        send_byte(pos[7:0]);
        send_byte({pos[11:8], len_code});
    endtask

    task automatic drain_idle();
        i_in_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_compressed_length <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        stop_len = value;
    endtask

    task automatic send_block(input int groups, input int lit_pct, input logic long_only);
        logic [7:0] desc;
        int g;
        int k;
        // finish any command left open by noise
        while (dec_phase != PH_CMD_START || (flags_left != 0 && consumed_cnt < stop_len))
            send_byte(8'($urandom_range(0, 255)));
        for (g = 0; g < groups; g++) begin
            for (k = 0; k < 8; k++) desc[k] = $urandom_range(0, 99) < lit_pct;
            send_byte(desc);
            for (k = 0; k < 8; k++) begin
                if (desc[k]) send_byte(8'($urandom_range(0, 255)));
                else send_match(pick_pos(), long_only ? 4'hF : 4'($urandom_range(0, 15)));
            end
        end
    endtask

    task automatic run_random(input int n_items, input int idle_pct, input int stall_pct);
        int target;
        in_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        target = taken_items + n_items;
        while (taken_items < target) begin
            if ($urandom_range(0, 99) < 85) send_block(1, 50, 1'b0);
            else repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_stopped_after_reset();
        in_idle_pct = 0;
        out_stall_pct = 0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'($urandom_range(0, 255)));
        drain_idle();
        set_length(16'h0000);
        send_byte(8'h01);
        drain_idle();
        set_length(16'hFFFF);
    endtask

    task automatic test_literals_and_matches();
        send_byte(8'h0F);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        // too far back: zero fill
        send_match(12'hFFF, 4'hF);
        // overlapping copy of the previous byte
        send_match(pos_for_dist(1), 4'hF);
        send_match(pos_for_dist(written_cnt), 4'h0);
        send_match(12'h000, 4'h7);
        drain_idle();
    endtask

    task automatic test_length_boundary();
        // command after a descriptor is taken past the length
        set_length(consumed_cnt + 16'd1);
        send_byte(8'h01);
        send_byte(8'h5A);
        send_byte(8'h33);
        drain_idle();
        // high byte of a match is taken past the length
        set_length(consumed_cnt + 16'd1);
        send_match(12'h010, 4'h2);
        send_byte(8'h44);
        drain_idle();
        set_length(16'hFFFF);
    endtask

    task automatic test_window_fill();
        in_idle_pct = 0;
        out_stall_pct = 0;
        while (written_cnt < 13'(LZWD_WINDOW_SIZE)) send_block(1, 0, 1'b1);
        send_block(4, 0, 1'b1);
        drain_idle();
    endtask

    task automatic test_random_phases();
        run_random(100, 0, 0);
        run_random(100, 74, 0);
        run_random(100, 0, 74);
        run_random(100, 10, 10);
        drain_idle();
    endtask

    task automatic test_backpressure();
        in_idle_pct = 0;
        out_stall_pct = 0;
        hold_cycles = 400;
        send_block(6, 30, 1'b0);
        drain_idle();
    endtask

    task automatic test_random_stop();
        in_idle_pct = 30;
        out_stall_pct = 30;
        set_length(consumed_cnt + 16'd100);
        while (!(dec_phase == PH_CMD_START && consumed_cnt >= stop_len))
            send_block(1, 50, 1'b0);
        repeat (8) send_byte(8'($urandom_range(0, 255)));
        drain_idle();
        set_length(16'hFFFF);
        send_block(2, 50, 1'b0);
        drain_idle();
    endtask

    initial begin
        t_out_byte exp_item;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
                if (expected_out.size() == 0) begin
                    $error("out_byte %02h transfer with nothing expected", o_out_byte);
                    fail_cnt++;
                end else begin
                    exp_item = expected_out.pop_front();
                    if (o_out_byte !== exp_item.data) begin
                        $error("out_byte: expected %02h, actual %02h", exp_item.data, o_out_byte);
                        fail_cnt++;
                    end
                    if (o_last_of_run !== exp_item.last) begin
                        $error("last_of_run: expected %0b, actual %0b", exp_item.last,
                               o_last_of_run);
                        fail_cnt++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= $urandom_range(0, 99) >= out_stall_pct;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_compressed_length = '0;
        i_in_valid = 1'b0;
        i_in_byte = '0;
        wr_ptr = '0;
        written_cnt = '0;
        consumed_cnt = '0;
        flag_sr = '0;
        flags_left = '0;
        dec_phase = PH_CMD_START;
        saved_low = '0;
        stop_len = '0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        hold_cycles = 0;
        taken_items = 0;
        fail_cnt = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_stopped_after_reset();
        test_literals_and_matches();
        test_length_boundary();
        test_window_fill();
        test_random_phases();
        test_backpressure();
        test_random_stop();
        drain_idle();
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
